[design/bss_pkg.sv]
// ---------------------------------------------------------------------------
// bss_pkg: shared types and constants for the baud scale/step search
// field widths, register map and search limits
// ---------------------------------------------------------------------------
package bss_pkg;

  localparam int BAUD_W   = 24;
  localparam int SCALE_W  = 8;
  localparam int STEP_W   = 16;
  localparam int CLK_W    = 32;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // prescalers 0 .. SCALE_LIMIT-1 are tried
  localparam logic [SCALE_W-1:0] SCALE_LIMIT = 8'd255;

  localparam logic [CLK_W-1:0] CLOCK_RATE_RST = 32'd25000000;

  // register index of clock_rate in the config map
  localparam logic REG_CLOCK_RATE = 1'b0;

  typedef logic [BAUD_W-1:0]  baud_t;
  typedef logic [SCALE_W-1:0] scale_t;
  typedef logic [STEP_W-1:0]  step_t;

endpackage

[design/bss_if.sv]
// ---------------------------------------------------------------------------
// bss_in_if / bss_out_if: valid/ready channels of the baud scale/step search
// request channel carries the baud rate, result channel the chosen pair
// ---------------------------------------------------------------------------
interface bss_in_if import bss_pkg::*; ();
  logic  valid;
  logic  ready;
  baud_t baud_request;

  modport source (output valid, output baud_request, input ready);
  modport sink   (input valid, input baud_request, output ready);
endinterface

interface bss_out_if import bss_pkg::*; ();
  logic   valid;
  logic   ready;
  scale_t prescale;
  step_t  step_value;

  modport source (output valid, output prescale, output step_value, input ready);
  modport sink   (input valid, input prescale, input step_value, output ready);
endinterface

[design/baud_scale_step_search.sv]
// ---------------------------------------------------------------------------
// baud_scale_step_search: prescaler and fractional step search for a uart
// walks prescalers upward, divides on one shared restoring divider and keeps
// the prescaler/step pair whose rounded achieved rate is closest to the request
// ---------------------------------------------------------------------------
//  channel   direction  payload                   transfer when
//  in_chan   sink       baud_request[23:0]        valid && ready
//  out_chan  source     prescale[7:0],            valid && ready
//                       step_value[15:0]
//  cfg_*     apb slave  clock_rate @ 0x0          psel && penable && pwrite
//
//  each prescaler steps through an overflow check, the step divide, a
//  multiply, a round-add, the rate divide and a compare; both divides run
//  on the single divider, one quotient bit per cycle. the search ends when
//  the step overflows or after all 255 prescalers; a zero clock_rate skips
//  it. the result then loads into the output register once that is free.
//  in_chan.ready is high only while idle; a finished result sits in the output
//  register, so the next request is taken while it waits for out_chan.ready.
//  rst_n is synchronous and active low; clock_rate resets to 25000000.
// ---------------------------------------------------------------------------
module baud_scale_step_search import bss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bss_in_if.sink             in_chan,
  bss_out_if.source          out_chan,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV1  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_DIV2  = 3'd5;
  localparam logic [2:0] ST_CMP   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CLK_W-1:0] clock_rate_r;
  logic             out_valid_r, out_valid_nxt;

  baud_t            baud_r, baud_nxt;
  logic [CLK_W-1:0] prod_r, prod_nxt;
  scale_t           sp1_r, sp1_nxt;
  logic [CLK_W-1:0] rem_r, rem_nxt;
  logic [CLK_W-1:0] quo_r, quo_nxt;
  logic [CLK_W-1:0] dvs_r, dvs_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  step_t            step_r, step_nxt;
  logic [47:0]      mul_r, mul_nxt;
  baud_t            best_err_r, best_err_nxt;
  scale_t           best_scale_r, best_scale_nxt;
  step_t            best_step_r, best_step_nxt;
  scale_t           out_prescale_r, out_prescale_nxt;
  step_t            out_step_r, out_step_nxt;

  logic             in_xfer;
  logic             cfg_wr;
  logic [CLK_W:0]   div_trial;
  logic             div_ge;
  logic [CLK_W-1:0] div_rem;
  logic [CLK_W-1:0] div_quo;
  logic             ovf;
  logic [48:0]      round_sum;
  logic [CLK_W-1:0] err;
  logic             better;

  assign in_chan.ready   = (state_r == ST_IDLE);
  assign in_xfer         = in_chan.valid && in_chan.ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.prescale   = out_prescale_r;
  assign out_chan.step_value = out_step_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_CLOCK_RATE) ? clock_rate_r : '0;

  // shared restoring divider, one quotient bit per cycle
  assign div_trial = {rem_r, quo_r[CLK_W-1]};
  assign div_ge    = div_trial >= {1'b0, dvs_r};
  assign div_rem   = div_ge ? CLK_W'(div_trial - {1'b0, dvs_r}) : div_trial[CLK_W-1:0];
  assign div_quo   = {quo_r[CLK_W-2:0], div_ge};

  // step >= 2^16 exactly when 2*baud*(s+1) >= clock_rate
  assign ovf = {prod_r, 1'b0} >= {1'b0, clock_rate_r};

  // clk*step + 2^16*(s+1), divided by 2^17 before the divider
  assign round_sum = {1'b0, mul_r} + {25'd0, sp1_r, 16'd0};

  assign err    = (quo_r >= {8'd0, baud_r}) ? (quo_r - {8'd0, baud_r})
                                            : ({8'd0, baud_r} - quo_r);
  assign better = err < {8'd0, best_err_r};

  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r;
    baud_nxt         = baud_r;
    prod_nxt         = prod_r;
    sp1_nxt          = sp1_r;
    rem_nxt          = rem_r;
    quo_nxt          = quo_r;
    dvs_nxt          = dvs_r;
    cnt_nxt          = cnt_r;
    step_nxt         = step_r;
    mul_nxt          = mul_r;
    best_err_nxt     = best_err_r;
    best_scale_nxt   = best_scale_r;
    best_step_nxt    = best_step_r;
    out_prescale_nxt = out_prescale_r;
    out_step_nxt     = out_step_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          baud_nxt       = in_chan.baud_request;
          prod_nxt       = {8'd0, in_chan.baud_request};
          sp1_nxt        = 8'd1;
          best_err_nxt   = in_chan.baud_request;
          best_scale_nxt = '0;
          best_step_nxt  = '0;
          state_nxt      = (clock_rate_r == '0) ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (ovf) begin
          state_nxt = ST_DONE;
        end else begin
          // remainder starts below the divisor, low 16 dividend bits are zero
          rem_nxt   = {prod_r[CLK_W-2:0], 1'b0};
          quo_nxt   = '0;
          dvs_nxt   = clock_rate_r;
          cnt_nxt   = 5'd15;
          state_nxt = ST_DIV1;
        end
      end
      ST_DIV1: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_nxt   = 48'(clock_rate_r) * 48'(quo_r[STEP_W-1:0]);
        step_nxt  = quo_r[STEP_W-1:0];
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        quo_nxt   = round_sum[48:17];
        rem_nxt   = '0;
        dvs_nxt   = {24'd0, sp1_r};
        cnt_nxt   = 5'd31;
        state_nxt = ST_DIV2;
      end
      ST_DIV2: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (better) begin
          best_err_nxt   = err[BAUD_W-1:0];
          best_scale_nxt = sp1_r - 8'd1;
          best_step_nxt  = step_r;
        end
        if (sp1_r == SCALE_LIMIT) begin
          state_nxt = ST_DONE;
        end else begin
          sp1_nxt   = sp1_r + 8'd1;
          prod_nxt  = prod_r + {8'd0, baud_r};
          state_nxt = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_prescale_nxt = best_scale_r;
          out_step_nxt     = best_step_r;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      clock_rate_r <= CLOCK_RATE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (cfg_paddr[2] == REG_CLOCK_RATE)) begin
        clock_rate_r <= cfg_pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    baud_r         <= baud_nxt;
    prod_r         <= prod_nxt;
    sp1_r          <= sp1_nxt;
    rem_r          <= rem_nxt;
    quo_r          <= quo_nxt;
    dvs_r          <= dvs_nxt;
    cnt_r          <= cnt_nxt;
    step_r         <= step_nxt;
    mul_r          <= mul_nxt;
    best_err_r     <= best_err_nxt;
    best_scale_r   <= best_scale_nxt;
    best_step_r    <= best_step_nxt;
    out_prescale_r <= out_prescale_nxt;
    out_step_r     <= out_step_nxt;
  end

endmodule
